// ===== sv/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types and constants for the FSK proximity card bit demodulator.
// ----------------------------------------------------------------------------
package fpd_pkg;

  // widths of the item fields
  localparam int unsigned DurW    = 16;
  localparam int unsigned WindowW = 96;
  localparam int unsigned WordW   = 32;
  localparam int unsigned RunW    = 3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgLowLimit    = 2'd0,
    CfgMiddleLimit = 2'd1,
    CfgHighLimit   = 2'd2,
    CfgUnused      = 2'd3
  } cfg_idx_e;

  // register reset values, in clock ticks
  localparam logic [DurW-1:0] LowLimitRst    = 16'd2816;
  localparam logic [DurW-1:0] MiddleLimitRst = 16'd4608;
  localparam logic [DurW-1:0] HighLimitRst   = 16'd6400;

  // run lengths of like periods
  localparam logic [RunW-1:0] ShortRunFull = 3'd6;
  localparam logic [RunW-1:0] LongRunFull  = 3'd5;
  localparam logic [RunW-1:0] ShortRunMin  = 3'd3;
  localparam logic [RunW-1:0] LongRunMin   = 3'd2;

  // saturation value of the period sum
  localparam logic [DurW-1:0] SumMax = 16'hFFFF;

  // period classes
  localparam logic ClassShort = 1'b0;
  localparam logic ClassLong  = 1'b1;

  // one result word as it sits in the output queue
  typedef struct packed {
    logic [WindowW-1:0] window;
    logic               bit_value;
  } fpd_result_t;

endpackage

// ===== sv/fpd_out_buf.sv =====
// ----------------------------------------------------------------------------
// fpd_out_buf
// Two-entry output queue, so that a new edge word is taken while a result
// still waits for the sink.
// ----------------------------------------------------------------------------
module fpd_out_buf
  import fpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  fpd_result_t push_data_i,
  output logic        full_o,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output fpd_result_t pop_data_o
);

  fpd_result_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop_data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/fsk_prox_card_bit_demodulator.sv =====
// ----------------------------------------------------------------------------
// fsk_prox_card_bit_demodulator
// Turns carrier edge words into demodulated data bits and a 96-bit window.
// ----------------------------------------------------------------------------
// Each edge word (polarity in tuser, duration in tdata) is fully processed in
// the cycle it is taken; one word per clock is sustained while tready is high.
// A rising edge loads the period sum, a falling edge adds to it (saturating
// at 65535) and, if the sum lies strictly between the low and high limits,
// classes it as short or long against the middle limit. Six short periods
// give a 0, five long periods give a 1, and a shorter run that ends on a
// class change still gives a bit if it held more than three short or more
// than two long periods. Each bit is shifted into the window and the bit
// plus window are registered into a two-entry output queue, from which
// the sink takes them; tready on the input drops only when both queue entries wait.
// Users write limits via the cfg port while the block is idle; it is not enforced.
module fsk_prox_card_bit_demodulator
  import fpd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  // edge words
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,   // [15:0] duration
  input  logic         s_axis_tuser_i,   // [0] polarity
  // result words
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o    // [0] bit_value, [32:1] window_high,
                                         // [64:33] window_mid, [96:65] window_low
);

  logic [DurW-1:0]    low_limit_q, middle_limit_q, high_limit_q;
  logic [DurW-1:0]    period_sum_q, period_sum_d;
  logic               last_class_q, last_class_d;
  logic [RunW-1:0]    run_count_q, run_count_d;
  logic [WindowW-1:0] window_q, window_d;

  logic               accept;
  logic               buf_full;
  logic [DurW:0]      sum_wide;
  logic [DurW-1:0]    sum_sat;
  logic               in_band;
  logic               cls;
  logic [RunW-1:0]    run_inc;
  logic               emit;
  logic               emit_bit;
  fpd_result_t        push_data;
  fpd_result_t        pop_data;

  assign s_axis_tready_o = !buf_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q    <= LowLimitRst;
      middle_limit_q <= MiddleLimitRst;
      high_limit_q   <= HighLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgLowLimit:    low_limit_q    <= cfg_data_i;
        CfgMiddleLimit: middle_limit_q <= cfg_data_i;
        CfgHighLimit:   high_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturating period sum and classification
  assign sum_wide = {1'b0, period_sum_q} + {1'b0, s_axis_tdata_i};
  assign sum_sat  = sum_wide[DurW] ? SumMax : sum_wide[DurW-1:0];
  assign in_band  = (sum_sat > low_limit_q) && (sum_sat < high_limit_q);
  assign cls      = (sum_sat < middle_limit_q) ? ClassShort : ClassLong;
  assign run_inc  = run_count_q + 3'd1;

  // run counting and bit decision
  always_comb begin
    period_sum_d = period_sum_q;
    last_class_d = last_class_q;
    run_count_d  = run_count_q;
    emit         = 1'b0;
    emit_bit     = 1'b0;
    if (accept) begin
      if (s_axis_tuser_i) begin
        period_sum_d = s_axis_tdata_i;
      end else begin
        period_sum_d = sum_sat;
        if (in_band) begin
          if (cls == last_class_q) begin
            run_count_d = run_inc;
            if (cls == ClassLong) begin
              if (run_inc >= LongRunFull) begin
                run_count_d = '0;
                emit        = 1'b1;
                emit_bit    = 1'b1;
              end
            end else if (run_inc >= ShortRunFull) begin
              run_count_d = '0;
              emit        = 1'b1;
              emit_bit    = 1'b0;
            end
          end else begin
            // class change ends the run, a long enough run still counts
            if (last_class_q == ClassLong) begin
              emit = (run_count_q > LongRunMin);
            end else begin
              emit = (run_count_q > ShortRunMin);
            end
            emit_bit     = last_class_q;
            run_count_d  = '0;
            last_class_d = cls;
          end
        end
      end
    end
  end

  // bit window shift
  assign window_d = emit ? {window_q[WindowW-2:0], emit_bit} : window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_sum_q <= '0;
      last_class_q <= ClassShort;
      run_count_q  <= '0;
      window_q     <= '0;
    end else begin
      period_sum_q <= period_sum_d;
      last_class_q <= last_class_d;
      run_count_q  <= run_count_d;
      window_q     <= window_d;
    end
  end

  // result queue
  assign push_data.window    = window_d;
  assign push_data.bit_value = emit_bit;

  fpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_data_i (push_data),
    .full_o      (buf_full),
    .pop_valid_o (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .pop_data_o  (pop_data)
  );

  // output word packing
  assign m_axis_tdata_o = {7'd0,
                           pop_data.window[WordW-1:0],
                           pop_data.window[2*WordW-1:WordW],
                           pop_data.window[WindowW-1:2*WordW],
                           pop_data.bit_value};

endmodule
